[design/flowlet_path_balancer_macros.svh]
// Assertion macros shared by the flowlet path balancer RTL.
`ifndef FLOWLET_PATH_BALANCER_MACROS_SVH
`define FLOWLET_PATH_BALANCER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define FPB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define FPB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/fpb_pkg.sv]
// Package: types, constants and helpers of the flowlet path balancer.
`default_nettype none

package fpb_pkg;

    // Sizes
    localparam int DEF_TABLE_ENTRIES = 1024;
    localparam int PORTS             = 16;
    localparam int PORT_W            = 4;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 48;
    localparam int TIME_W            = 48;
    localparam int REM_W             = 17;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE            = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEED            = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NODE_ID         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FLOW_TIMEOUT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FLOWLET_TIMEOUT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PORT_PRESENT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PORT        = 3'd6;

    // Balancing modes
    localparam logic [1:0] MODE_ECMP    = 2'd0;
    localparam logic [1:0] MODE_BURST   = 2'd1;
    localparam logic [1:0] MODE_FLOWLET = 2'd2;

    // Reset values
    localparam logic [31:0]     RST_SEED            = 32'd1806;
    localparam logic [TIME_W-1:0] RST_FLOW_TIMEOUT    = 48'd1000000;
    localparam logic [TIME_W-1:0] RST_FLOWLET_TIMEOUT = 48'd100000;
    localparam logic [15:0]     RST_PORT_PRESENT    = 16'hFFFF;
    localparam logic [PORT_W-1:0] RST_MAX_PORT        = 4'd15;

    // Hash constants
    localparam logic [31:0] MM_C1  = 32'hcc9e2d51;
    localparam logic [31:0] MM_C2  = 32'h1b873593;
    localparam logic [31:0] MM_ADD = 32'he6546b64;
    localparam logic [31:0] MM_F1  = 32'h85ebca6b;
    localparam logic [31:0] MM_F2  = 32'hc2b2ae35;

    // Controller states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH_KEY,
        ST_HASH_IDX,
        ST_MOD_IDX,
        ST_READ,
        ST_DECIDE,
        ST_HASH_EGR,
        ST_WRITE,
        ST_MOD_PORT,
        ST_OUT
    } ctrl_state_t;

    // Hash unit phases
    typedef enum logic [2:0] {
        HP_IDLE,
        HP_K1,
        HP_K2,
        HP_MIX,
        HP_FIN1,
        HP_FIN2,
        HP_DONE
    } hash_phase_t;

    // What the hash unit reads
    typedef enum logic [1:0] {
        HSRC_KEY,
        HSRC_FLOW,
        HSRC_EGR
    } hash_src_t;

    typedef struct packed {
        logic      clr_en;
        logic      in_load;
        logic      hash_start;
        hash_src_t hash_src;
        logic      f_load;
        logic      mod_start;
        logic      mod_div_port;
        logic      mod_from_sel;
        logic      idx_load;
        logic      mem_rd;
        logic      decide;
        logic      egr_load;
        logic      mem_wr;
        logic      out_load;
    } fpb_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic hash_done;
        logic mod_done;
        logic use_table;
        logic need_rehash;
        logic out_free;
    } fpb_sts_t;

    typedef struct packed {
        logic              valid;
        logic [31:0]       key;
        logic [15:0]       count;
        logic              pinned;
        logic [31:0]       egress;
        logic [TIME_W-1:0] stamp;
    } burst_ent_t;

    typedef struct packed {
        logic              valid;
        logic [31:0]       egress;
        logic [TIME_W-1:0] stamp;
    } flow_ent_t;

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int r);
        return (v << r) | (v >> (32 - r));
    endfunction

endpackage

`default_nettype wire

[design/flowlet_path_balancer.sv]
// Flowlet path balancer: one packet at a time is hashed (4-word Murmur over node id,
// source, destination and flow number) and mapped to an output port by ECMP, a burst
// table or a flowlet table. All hashing goes through one iterative hash unit doing one
// multiply per cycle; a finished result waits in an output register while the next
// packet is taken in. After reset the tables are swept clear, one entry a cycle, and no
// packet is taken during that sweep; configuration writes are taken at any time but must
// only be made while the block is idle.
`default_nettype none
`include "flowlet_path_balancer_macros.svh"

module flowlet_path_balancer #(
    parameter int TABLE_ENTRIES = fpb_pkg::DEF_TABLE_ENTRIES
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // packet in: src_node[31:0], dst_node[63:32], flow_number[95:64], arrival_time[143:96]
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [143:0] s_axis_tdata,
    // result out: port[3:0], zero[7:4]
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [7:0]        m_axis_tdata,
    // result flag: no_live_port[0]
    output logic [0:0]        m_axis_tuser,
    // configuration write
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [fpb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [fpb_pkg::CFG_DATA_W-1:0] cfg_data
);

    fpb_pkg::fpb_cmd_t          cmd;
    fpb_pkg::fpb_sts_t          sts;
    logic [fpb_pkg::PORT_W-1:0] port;
    logic                       no_live_port;

    fpb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .sts      (sts),
        .in_ready (s_axis_tready),
        .cmd      (cmd)
    );

    fpb_dpath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .src_node     (s_axis_tdata[31:0]),
        .dst_node     (s_axis_tdata[63:32]),
        .flow_number  (s_axis_tdata[95:64]),
        .arrival_time (s_axis_tdata[143:96]),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .port         (port),
        .no_live_port (no_live_port)
    );

    assign m_axis_tdata = {4'd0, port};
    assign m_axis_tuser = no_live_port;

    // No packet is taken while the tables are being cleared
    `FPB_ASSERT_NOW(a_no_take_in_clear, clk, rst_n, cmd.clr_en, !s_axis_tready,
                    "packet input open during table clear")
    // A result is only loaded when the output register can take it
    `FPB_ASSERT_NOW(a_out_load_free, clk, rst_n, cmd.out_load, sts.out_free,
                    "result loaded over an untaken result")
    // One packet at a time: the input closes right after a transfer
    `FPB_ASSERT_NEXT(a_one_in_flight, clk, rst_n, s_axis_tvalid && s_axis_tready,
                     !s_axis_tready, "second packet taken while one is in flight")
    // A loaded result is offered in the next cycle
    `FPB_ASSERT_NEXT(a_out_shown, clk, rst_n, cmd.out_load, m_axis_tvalid,
                     "loaded result not offered")

endmodule

`default_nettype wire

[design/fpb_hash.sv]
// Iterative 32-bit Murmur hash unit, one multiply per cycle.
`default_nettype none

module fpb_hash (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [2:0]  nwords,
    input  wire logic [31:0] seed,
    input  wire logic [31:0] word,
    output logic [1:0]       word_idx,
    output logic             done,
    output logic [31:0]      result
);

    fpb_pkg::hash_phase_t phase_reg, phase_next;
    logic [31:0] h_reg, h_next;
    logic [31:0] k_reg, k_next;
    logic [1:0]  idx_reg, idx_next;
    logic [2:0]  n_reg, n_next;
    logic [31:0] mix_t;
    logic [31:0] fin_t;

    // Phase register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= fpb_pkg::HP_IDLE;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        h_reg   <= h_next;
        k_reg   <= k_next;
        idx_reg <= idx_next;
        n_reg   <= n_next;
    end

    // One step per phase; each multiply lands in a register
    always_comb
    begin
        phase_next = phase_reg;
        h_next     = h_reg;
        k_next     = k_reg;
        idx_next   = idx_reg;
        n_next     = n_reg;
        mix_t      = h_reg ^ k_reg;
        fin_t      = 32'd0;
        case (phase_reg)
            fpb_pkg::HP_IDLE:
            begin
            end
            fpb_pkg::HP_K1:
            begin
                k_next     = word * fpb_pkg::MM_C1;
                phase_next = fpb_pkg::HP_K2;
            end
            fpb_pkg::HP_K2:
            begin
                k_next     = fpb_pkg::rotl32(k_reg, 15) * fpb_pkg::MM_C2;
                phase_next = fpb_pkg::HP_MIX;
            end
            fpb_pkg::HP_MIX:
            begin
                mix_t  = fpb_pkg::rotl32(h_reg ^ k_reg, 13);
                h_next = mix_t + (mix_t << 2) + fpb_pkg::MM_ADD;
                if ({1'b0, idx_reg} == n_reg - 3'd1)
                begin
                    phase_next = fpb_pkg::HP_FIN1;
                end
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    phase_next = fpb_pkg::HP_K1;
                end
            end
            fpb_pkg::HP_FIN1:
            begin
                fin_t      = h_reg ^ {27'd0, n_reg, 2'b00};
                fin_t      = fin_t ^ (fin_t >> 16);
                h_next     = fin_t * fpb_pkg::MM_F1;
                phase_next = fpb_pkg::HP_FIN2;
            end
            fpb_pkg::HP_FIN2:
            begin
                fin_t      = h_reg ^ (h_reg >> 13);
                h_next     = fin_t * fpb_pkg::MM_F2;
                phase_next = fpb_pkg::HP_DONE;
            end
            fpb_pkg::HP_DONE:
            begin
                phase_next = fpb_pkg::HP_IDLE;
            end
            default:
            begin
                phase_next = fpb_pkg::HP_IDLE;
            end
        endcase
        if (start)
        begin
            h_next     = seed;
            idx_next   = 2'd0;
            n_next     = nwords;
            phase_next = fpb_pkg::HP_K1;
        end
    end

    assign word_idx = idx_reg;
    assign done     = (phase_reg == fpb_pkg::HP_DONE);
    assign result   = h_reg ^ (h_reg >> 16);

endmodule

`default_nettype wire

[design/fpb_ctrl.sv]
// Controller state machine sequencing one packet through the datapath.
`default_nettype none

module fpb_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire fpb_pkg::fpb_sts_t sts,
    output logic                  in_ready,
    output fpb_pkg::fpb_cmd_t     cmd
);

    fpb_pkg::ctrl_state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fpb_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.hash_src = fpb_pkg::HSRC_KEY;
        in_ready   = 1'b0;
        case (state_reg)
            fpb_pkg::ST_CLEAR:
            begin
                cmd.clr_en = 1'b1;
                if (sts.clr_done)
                begin
                    state_next = fpb_pkg::ST_IDLE;
                end
            end
            fpb_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.in_load    = 1'b1;
                    cmd.hash_start = 1'b1;
                    cmd.hash_src   = fpb_pkg::HSRC_KEY;
                    state_next     = fpb_pkg::ST_HASH_KEY;
                end
            end
            fpb_pkg::ST_HASH_KEY:
            begin
                if (sts.hash_done)
                begin
                    cmd.f_load = 1'b1;
                    if (sts.use_table)
                    begin
                        cmd.hash_start = 1'b1;
                        cmd.hash_src   = fpb_pkg::HSRC_FLOW;
                        state_next     = fpb_pkg::ST_HASH_IDX;
                    end
                    else
                    begin
                        cmd.mod_start    = 1'b1;
                        cmd.mod_div_port = 1'b1;
                        state_next       = fpb_pkg::ST_MOD_PORT;
                    end
                end
            end
            fpb_pkg::ST_HASH_IDX:
            begin
                if (sts.hash_done)
                begin
                    cmd.mod_start = 1'b1;
                    state_next    = fpb_pkg::ST_MOD_IDX;
                end
            end
            fpb_pkg::ST_MOD_IDX:
            begin
                if (sts.mod_done)
                begin
                    cmd.idx_load = 1'b1;
                    state_next   = fpb_pkg::ST_READ;
                end
            end
            fpb_pkg::ST_READ:
            begin
                cmd.mem_rd = 1'b1;
                state_next = fpb_pkg::ST_DECIDE;
            end
            fpb_pkg::ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                if (sts.need_rehash)
                begin
                    cmd.hash_start = 1'b1;
                    cmd.hash_src   = fpb_pkg::HSRC_EGR;
                    state_next     = fpb_pkg::ST_HASH_EGR;
                end
                else
                begin
                    state_next = fpb_pkg::ST_WRITE;
                end
            end
            fpb_pkg::ST_HASH_EGR:
            begin
                cmd.hash_src = fpb_pkg::HSRC_EGR;
                if (sts.hash_done)
                begin
                    cmd.egr_load = 1'b1;
                    state_next   = fpb_pkg::ST_WRITE;
                end
            end
            fpb_pkg::ST_WRITE:
            begin
                cmd.mem_wr       = 1'b1;
                cmd.mod_start    = 1'b1;
                cmd.mod_div_port = 1'b1;
                cmd.mod_from_sel = 1'b1;
                state_next       = fpb_pkg::ST_MOD_PORT;
            end
            fpb_pkg::ST_MOD_PORT:
            begin
                if (sts.mod_done)
                begin
                    state_next = fpb_pkg::ST_OUT;
                end
            end
            fpb_pkg::ST_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = fpb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fpb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[design/fpb_dpath.sv]
// Datapath: configuration, hash operands, remainder unit, flow tables, port choice.
`default_nettype none

module fpb_dpath #(
    parameter int TABLE_ENTRIES = fpb_pkg::DEF_TABLE_ENTRIES
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire fpb_pkg::fpb_cmd_t             cmd,
    output fpb_pkg::fpb_sts_t                  sts,
    // configuration
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [fpb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [fpb_pkg::CFG_DATA_W-1:0] cfg_data,
    // packet fields
    input  wire logic [31:0]                   src_node,
    input  wire logic [31:0]                   dst_node,
    input  wire logic [31:0]                   flow_number,
    input  wire logic [fpb_pkg::TIME_W-1:0]    arrival_time,
    // result
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [fpb_pkg::PORT_W-1:0]         port,
    output logic                               no_live_port
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [fpb_pkg::REM_W-1:0] TABLE_DIV = fpb_pkg::REM_W'(TABLE_ENTRIES);

    // Configuration registers
    logic [1:0]                  mode_reg;
    logic [31:0]                 seed_reg;
    logic [31:0]                 node_id_reg;
    logic [fpb_pkg::TIME_W-1:0]  flow_to_reg;
    logic [fpb_pkg::TIME_W-1:0]  flowlet_to_reg;
    logic [15:0]                 present_reg;
    logic [fpb_pkg::PORT_W-1:0]  max_port_reg;

    // Packet registers
    logic [31:0]                 src_reg, dst_reg, flow_reg;
    logic [fpb_pkg::TIME_W-1:0]  now_reg;
    logic [31:0]                 f_reg;
    logic [31:0]                 egr_reg;
    fpb_pkg::hash_src_t          hsrc_reg;
    logic [IW-1:0]               idx_reg;

    // Table and decision registers
    fpb_pkg::burst_ent_t         burst_mem [TABLE_ENTRIES];
    fpb_pkg::flow_ent_t          flow_mem  [TABLE_ENTRIES];
    fpb_pkg::burst_ent_t         rd_b_reg;
    fpb_pkg::flow_ent_t          rd_f_reg;
    logic                        b_exp_reg, b_keq_reg, b_fl_reg, f_fl_reg;
    logic [IW-1:0]               clr_idx_reg;

    // Remainder unit
    logic [31:0]                 mod_val_reg, mod_val_next;
    logic [fpb_pkg::REM_W-1:0]   mod_rem_reg, mod_rem_next;
    logic [fpb_pkg::REM_W-1:0]   mod_div_reg;
    logic [1:0]                  mod_cnt_reg;
    logic                        mod_busy_reg;

    // Output register
    logic                        out_valid_reg;
    logic [fpb_pkg::PORT_W-1:0]  out_port_reg;
    logic                        out_nolive_reg;

    // Hash unit wiring
    logic [1:0]                  h_idx;
    logic [31:0]                 h_word;
    logic                        h_done;
    logic [31:0]                 h_result;
    logic [2:0]                  h_nwords;
    fpb_pkg::hash_src_t          h_src;

    // Decision terms
    logic [fpb_pkg::TIME_W-1:0]  gap_b, gap_f;
    logic                        b_exp, b_keq, b_fl, f_fl;
    fpb_pkg::burst_ent_t         new_b;
    fpb_pkg::flow_ent_t          new_f;
    logic [31:0]                 sel_b, sel_val, mod_in;
    logic [4:0]                  m_val;

    // Port search
    logic [15:0]                 live;
    logic [fpb_pkg::PORT_W-1:0]  start_p;
    logic [4:0]                  cand;
    logic                        found;
    logic [fpb_pkg::PORT_W-1:0]  pick;

    function automatic fpb_pkg::burst_ent_t burst_load(input logic [31:0] f,
                                                       input logic [fpb_pkg::TIME_W-1:0] now);
        fpb_pkg::burst_ent_t e;
        e        = '0;
        e.valid  = 1'b1;
        e.key    = f;
        e.count  = 16'd1;
        e.stamp  = now;
        return e;
    endfunction

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= fpb_pkg::MODE_ECMP;
            seed_reg       <= fpb_pkg::RST_SEED;
            node_id_reg    <= 32'd0;
            flow_to_reg    <= fpb_pkg::RST_FLOW_TIMEOUT;
            flowlet_to_reg <= fpb_pkg::RST_FLOWLET_TIMEOUT;
            present_reg    <= fpb_pkg::RST_PORT_PRESENT;
            max_port_reg   <= fpb_pkg::RST_MAX_PORT;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                fpb_pkg::REG_MODE:            mode_reg       <= cfg_data[1:0];
                fpb_pkg::REG_SEED:            seed_reg       <= cfg_data[31:0];
                fpb_pkg::REG_NODE_ID:         node_id_reg    <= cfg_data[31:0];
                fpb_pkg::REG_FLOW_TIMEOUT:    flow_to_reg    <= cfg_data;
                fpb_pkg::REG_FLOWLET_TIMEOUT: flowlet_to_reg <= cfg_data;
                fpb_pkg::REG_PORT_PRESENT:    present_reg    <= cfg_data[15:0];
                fpb_pkg::REG_MAX_PORT:        max_port_reg   <= cfg_data[3:0];
                default:
                begin
                end
            endcase
        end
    end

    // Hash operand selection
    assign h_src    = cmd.hash_start ? cmd.hash_src : hsrc_reg;
    assign h_nwords = (cmd.hash_src == fpb_pkg::HSRC_KEY) ? 3'd4 : 3'd2;

    always_comb
    begin
        h_word = 32'd0;
        case (hsrc_reg)
            fpb_pkg::HSRC_KEY:
            begin
                case (h_idx)
                    2'd0:    h_word = node_id_reg;
                    2'd1:    h_word = src_reg;
                    2'd2:    h_word = dst_reg;
                    default: h_word = flow_reg;
                endcase
            end
            fpb_pkg::HSRC_FLOW:
            begin
                h_word = (h_idx == 2'd0) ? f_reg : 32'd0;
            end
            fpb_pkg::HSRC_EGR:
            begin
                if (h_idx == 2'd0)
                begin
                    h_word = (mode_reg == fpb_pkg::MODE_BURST) ? rd_b_reg.egress
                                                               : rd_f_reg.egress;
                end
            end
            default:
            begin
                h_word = 32'd0;
            end
        endcase
    end

    fpb_hash u_hash (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.hash_start),
        .nwords   (h_nwords),
        .seed     (seed_reg),
        .word     (h_word),
        .word_idx (h_idx),
        .done     (h_done),
        .result   (h_result)
    );

    // Packet and intermediate registers
    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            src_reg  <= src_node;
            dst_reg  <= dst_node;
            flow_reg <= flow_number;
            now_reg  <= arrival_time;
        end
        hsrc_reg <= h_src;
        if (cmd.f_load)
        begin
            f_reg <= h_result;
        end
        if (cmd.egr_load)
        begin
            egr_reg <= h_result;
        end
        // last remainder step lands in the same cycle
        if (cmd.idx_load)
        begin
            idx_reg <= mod_rem_next[IW-1:0];
        end
        if (cmd.decide)
        begin
            b_exp_reg <= b_exp;
            b_keq_reg <= b_keq;
            b_fl_reg  <= b_fl;
            f_fl_reg  <= f_fl;
        end
    end

    // Remainder unit: eight quotient bits per cycle until the 32-bit value is done
    assign m_val = ((5'(max_port_reg) + 5'd1) > 5'(fpb_pkg::PORTS))
                   ? 5'(fpb_pkg::PORTS) : (5'(max_port_reg) + 5'd1);
    assign mod_in = cmd.mod_from_sel ? sel_val : h_result;

    always_comb
    begin
        logic [fpb_pkg::REM_W:0] r;
        r            = {1'b0, mod_rem_reg};
        mod_val_next = mod_val_reg;
        for (int i = 0; i < 8; i++)
        begin
            r = {r[fpb_pkg::REM_W-1:0], mod_val_next[31]};
            if (r >= {1'b0, mod_div_reg})
            begin
                r = r - {1'b0, mod_div_reg};
            end
            mod_val_next = mod_val_next << 1;
        end
        mod_rem_next = r[fpb_pkg::REM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_busy_reg <= 1'b0;
            mod_cnt_reg  <= 2'd0;
        end
        else if (cmd.mod_start)
        begin
            mod_busy_reg <= 1'b1;
            mod_cnt_reg  <= 2'd0;
        end
        else if (mod_busy_reg)
        begin
            mod_cnt_reg <= mod_cnt_reg + 2'd1;
            if (mod_cnt_reg == 2'd3)
            begin
                mod_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mod_start)
        begin
            mod_val_reg <= mod_in;
            mod_rem_reg <= '0;
            mod_div_reg <= cmd.mod_div_port ? fpb_pkg::REM_W'(m_val) : TABLE_DIV;
        end
        else if (mod_busy_reg)
        begin
            mod_val_reg <= mod_val_next;
            mod_rem_reg <= mod_rem_next;
        end
    end

    // Clearing sweep after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg <= '0;
        end
        else if (cmd.clr_en)
        begin
            clr_idx_reg <= clr_idx_reg + IW'(1);
        end
    end

    // Table memories: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.clr_en)
        begin
            burst_mem[clr_idx_reg] <= '0;
            flow_mem[clr_idx_reg]  <= '0;
        end
        else if (cmd.mem_wr)
        begin
            if (mode_reg == fpb_pkg::MODE_BURST)
            begin
                burst_mem[idx_reg] <= new_b;
            end
            else
            begin
                flow_mem[idx_reg] <= new_f;
            end
        end
        if (cmd.mem_rd)
        begin
            rd_b_reg <= burst_mem[idx_reg];
            rd_f_reg <= flow_mem[idx_reg];
        end
    end

    // Idle gaps and timeouts from the entry just read
    assign gap_b = now_reg - rd_b_reg.stamp;
    assign gap_f = now_reg - rd_f_reg.stamp;
    assign b_exp = !rd_b_reg.valid || (gap_b > flow_to_reg);
    assign b_keq = (rd_b_reg.key == f_reg);
    assign b_fl  = gap_b > flowlet_to_reg;
    assign f_fl  = gap_f > flowlet_to_reg;

    // Entry update and the value that picks the port
    always_comb
    begin
        new_b = rd_b_reg;
        sel_b = f_reg;
        if (b_exp_reg)
        begin
            new_b = burst_load(f_reg, now_reg);
        end
        else if (!b_keq_reg)
        begin
            if (rd_b_reg.count != 16'd0)
            begin
                new_b.count = rd_b_reg.count - 16'd1;
            end
            else if (!rd_b_reg.pinned)
            begin
                new_b = burst_load(f_reg, now_reg);
            end
        end
        else
        begin
            if (b_fl_reg)
            begin
                if (!rd_b_reg.pinned)
                begin
                    new_b.pinned = 1'b1;
                    new_b.egress = f_reg;
                end
                else
                begin
                    new_b.egress = egr_reg;
                end
            end
            if (rd_b_reg.count != 16'hFFFF)
            begin
                new_b.count = rd_b_reg.count + 16'd1;
            end
            new_b.stamp = now_reg;
            if (new_b.pinned)
            begin
                sel_b = new_b.egress;
            end
        end

        new_f = rd_f_reg;
        if (!rd_f_reg.valid)
        begin
            new_f.valid  = 1'b1;
            new_f.egress = f_reg;
        end
        else if (f_fl_reg)
        begin
            new_f.egress = egr_reg;
        end
        new_f.stamp = now_reg;

        sel_val = (mode_reg == fpb_pkg::MODE_BURST) ? sel_b : new_f.egress;
    end

    // First live port at or after the start, wrapping below M
    assign start_p = mod_rem_reg[fpb_pkg::PORT_W-1:0];

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            live[i] = present_reg[i] && (5'(i) < m_val);
        end
        found = 1'b0;
        pick  = (start_p == '0) ? fpb_pkg::PORT_W'(m_val - 5'd1)
                                : start_p - fpb_pkg::PORT_W'(1);
        for (int i = 0; i < fpb_pkg::PORTS; i++)
        begin
            cand = {1'b0, start_p} + 5'(i);
            if (cand >= m_val)
            begin
                cand = cand - m_val;
            end
            if (!found && (5'(i) < m_val) && live[cand[3:0]])
            begin
                found = 1'b1;
                pick  = cand[fpb_pkg::PORT_W-1:0];
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_port_reg   <= pick;
            out_nolive_reg <= !found;
        end
    end

    assign out_valid    = out_valid_reg;
    assign port         = out_port_reg;
    assign no_live_port = out_nolive_reg;

    // Status back to the controller
    assign sts.clr_done    = (clr_idx_reg == IW'(TABLE_ENTRIES - 1));
    assign sts.hash_done   = h_done;
    assign sts.mod_done    = mod_busy_reg && (mod_cnt_reg == 2'd3);
    assign sts.use_table   = (mode_reg == fpb_pkg::MODE_BURST) ||
                             (mode_reg == fpb_pkg::MODE_FLOWLET);
    assign sts.need_rehash = (mode_reg == fpb_pkg::MODE_BURST)
                             ? (!b_exp && b_keq && b_fl && rd_b_reg.pinned)
                             : ((mode_reg == fpb_pkg::MODE_FLOWLET) && rd_f_reg.valid && f_fl);
    assign sts.out_free    = !out_valid_reg || out_ready;

endmodule

`default_nettype wire
